### design/afd_pkg.sv
// Shared types, widths and constants for the audio FIR decimator.
// Holds the fixed-point coefficient table and the beat structs.
// No dependencies; every other design file but afd_ram references it by scoped name.
`default_nettype none

package afd_pkg;

    // Sizes
    localparam int unsigned TAPS               = 16;
    localparam int unsigned TAP_W              = $clog2(TAPS);
    localparam int unsigned SAMPLE_W           = 16;
    localparam int unsigned RATE_W             = 19;
    localparam int unsigned INDEX_W            = 32;
    localparam int unsigned WARMUP_LEN         = 15;
    localparam int unsigned COEF_FRACTION_BITS = 16;
    localparam int unsigned COEF_W             = COEF_FRACTION_BITS;
    localparam int unsigned PROD_W             = SAMPLE_W + COEF_W + 1;
    localparam int unsigned TERM_W             = SAMPLE_W + 1;
    localparam int unsigned ACC_W              = TERM_W + TAP_W;
    localparam int unsigned MUL_W              = INDEX_W + RATE_W;

    // Divider: numerator holds 2*k*in_rate + out_rate, divisor 2*out_rate
    localparam int unsigned DIV_RADIX_W = 4;
    localparam int unsigned DIV_NUM_W   = 56;
    localparam int unsigned DIV_DEN_W   = RATE_W + 1;
    localparam int unsigned DIV_STEPS   = DIV_NUM_W / DIV_RADIX_W;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int unsigned QUO_W       = INDEX_W;

    // APB
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // Reset values of the configuration registers
    localparam logic [RATE_W-1:0] IN_RATE_RESET  = RATE_W'(44100);
    localparam logic [RATE_W-1:0] OUT_RATE_RESET = RATE_W'(8000);

    // Output saturation limits
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(1 << (SAMPLE_W - 1)));
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

    // Register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_IN_RATE   = 2'd0,
        REG_OUT_RATE  = 2'd1,
        REG_STEREO    = 2'd2,
        REG_EIGHT_BIT = 2'd3
    } reg_idx_t;

    // Round a half-table coefficient (given in units of 1e-9) to fixed point
    function automatic logic [COEF_W-1:0] coef_fixed(input int unsigned half);
        logic [63:0] nano;
        logic [63:0] scaled;
        unique case (half)
            0:       nano = 64'd3638091;
            1:       nano = 64'd8158223;
            2:       nano = 64'd20889028;
            3:       nano = 64'd43770138;
            4:       nano = 64'd74889944;
            5:       nano = 64'd108669917;
            6:       nano = 64'd137467074;
            default: nano = 64'd154050524;
        endcase
        scaled = ((nano << COEF_FRACTION_BITS) + 64'd500000000) / 64'd1000000000;
        return scaled[COEF_W-1:0];
    endfunction

    // Outer half of the symmetric response, outermost tap first
    localparam logic [COEF_W-1:0] COEF_HALF [TAPS/2] = '{
        coef_fixed(0), coef_fixed(1), coef_fixed(2), coef_fixed(3),
        coef_fixed(4), coef_fixed(5), coef_fixed(6), coef_fixed(7)
    };

    // Beats
    typedef struct packed {
        logic                       start_stream;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } afd_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       saturated;
    } afd_out_t;

    // Divider control and status
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [QUO_W-1:0] quo;
    } div_stat_t;

    // History / tap sweep control and status
    typedef struct packed {
        logic                       clear;
        logic                       wr_en;
        logic signed [SAMPLE_W-1:0] wr_data;
        logic                       start;
        logic [TAP_W-1:0]           mean_last;
    } mac_req_t;

    typedef struct packed {
        logic                    busy;
        logic signed [ACC_W-1:0] fir_sum;
        logic signed [ACC_W-1:0] mean_sum;
    } mac_stat_t;

endpackage

`default_nettype wire

### design/audio_fir_decimator_core.sv
// Top level of the audio FIR decimator: handshakes, APB registers, sequencer.
// Depends on afd_pkg, afd_mac (history RAM and tap sweep) and afd_div.
//
// Channel  Role    Handshake                  Beat
// in       sink    in_valid / in_stall        afd_in_t, one PCM frame
// out      source  out_valid / out_stall      afd_out_t, one filtered sample
// cfg      APB     psel / penable / pready    32-bit register, 4 registers
//
// An accepted frame passes the history write and the sweep before the next accept; one
// that yields a sample also passes the output state, and a warm-up mean adds a division.
// The tap sweep sets the pace: the history RAM gives one word per cycle.
// The target-index division runs under the sweep.
// Reset and start_stream clear the 16 history valid bits at once: no clearing pass.
// A finished sample waits in the output register; the next frame is taken
// meanwhile and holds only when its own result finds that register still full.
`default_nettype none

module audio_fir_decimator_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire afd_pkg::afd_in_t               in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output afd_pkg::afd_out_t                   out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [afd_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [afd_pkg::PDATA_W-1:0]    pwdata,
    output logic      [afd_pkg::PDATA_W-1:0]    prdata,
    output logic                                pready
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WRITE = 5'b00010,
        S_RUN   = 5'b00100,
        S_MEAN  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t                              state_reg, state_next;
    logic [afd_pkg::RATE_W-1:0]          in_rate_reg, in_rate_next;
    logic [afd_pkg::RATE_W-1:0]          out_rate_reg, out_rate_next;
    logic                                stereo_reg, stereo_next;
    logic                                eight_bit_reg, eight_bit_next;
    logic [afd_pkg::INDEX_W-1:0]         in_idx_reg, in_idx_next;
    logic [afd_pkg::INDEX_W-1:0]         out_idx_reg, out_idx_next;
    logic                                out_valid_reg, out_valid_next;
    afd_pkg::afd_out_t                   out_data_reg, out_data_next;
    logic [afd_pkg::INDEX_W-1:0]         n_reg, n_next;
    logic [afd_pkg::MUL_W-1:0]           mul_reg, mul_next;
    logic signed [afd_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    afd_pkg::afd_out_t                   res_reg, res_next;
    logic                                neg_reg, neg_next;

    logic                                in_accept;
    logic                                cfg_write;
    logic                                rate_ok;
    logic                                match;
    logic                                warm;
    logic                                out_free;
    logic [afd_pkg::INDEX_W-1:0]         k_eff;
    logic signed [afd_pkg::SAMPLE_W-1:0] left_s, right_s;
    logic signed [afd_pkg::SAMPLE_W:0]   pair_sum, pair_adj;
    logic [afd_pkg::ACC_W-1:0]           mean_mag;
    logic [afd_pkg::SAMPLE_W-1:0]        mean_q;

    afd_pkg::mac_req_t                   mac_req;
    afd_pkg::mac_stat_t                  mac_stat;
    afd_pkg::div_req_t                   div_req;
    afd_pkg::div_stat_t                  div_stat;

    afd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .stat  (mac_stat)
    );

    afd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // Handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Frame to mono: scale 8-bit samples, average the pair toward zero
    assign left_s   = eight_bit_reg ? {in_data.left_sample[7:0], 8'h00} : in_data.left_sample;
    assign right_s  = eight_bit_reg ? {in_data.right_sample[7:0], 8'h00} : in_data.right_sample;
    assign pair_sum = {left_s[afd_pkg::SAMPLE_W-1], left_s}
                    + {right_s[afd_pkg::SAMPLE_W-1], right_s};
    assign pair_adj = pair_sum + {{afd_pkg::SAMPLE_W{1'b0}}, pair_sum[afd_pkg::SAMPLE_W]};

    assign k_eff   = in_data.start_stream ? '0 : out_idx_reg;
    assign rate_ok = (out_rate_reg != '0) && (in_rate_reg >= out_rate_reg);
    assign match   = rate_ok && (n_reg == div_stat.quo);
    assign warm    = (n_reg < afd_pkg::INDEX_W'(afd_pkg::WARMUP_LEN));

    assign mean_mag = mac_stat.mean_sum[afd_pkg::ACC_W-1] ? afd_pkg::ACC_W'(-mac_stat.mean_sum)
                                                           : afd_pkg::ACC_W'(mac_stat.mean_sum);
    assign mean_q   = div_stat.quo[afd_pkg::SAMPLE_W-1:0];

    // Configuration writes
    always_comb
    begin
        in_rate_next   = in_rate_reg;
        out_rate_next  = out_rate_reg;
        stereo_next    = stereo_reg;
        eight_bit_next = eight_bit_reg;
        if (cfg_write)
        begin
            unique case (afd_pkg::reg_idx_t'(paddr[3:2]))
                afd_pkg::REG_IN_RATE:   in_rate_next   = pwdata[afd_pkg::RATE_W-1:0];
                afd_pkg::REG_OUT_RATE:  out_rate_next  = pwdata[afd_pkg::RATE_W-1:0];
                afd_pkg::REG_STEREO:    stereo_next    = pwdata[0];
                afd_pkg::REG_EIGHT_BIT: eight_bit_next = pwdata[0];
                default:                in_rate_next   = in_rate_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (afd_pkg::reg_idx_t'(paddr[3:2]))
            afd_pkg::REG_IN_RATE:   prdata = afd_pkg::PDATA_W'(in_rate_reg);
            afd_pkg::REG_OUT_RATE:  prdata = afd_pkg::PDATA_W'(out_rate_reg);
            afd_pkg::REG_STEREO:    prdata = afd_pkg::PDATA_W'(stereo_reg);
            afd_pkg::REG_EIGHT_BIT: prdata = afd_pkg::PDATA_W'(eight_bit_reg);
            default:                prdata = '0;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        in_idx_next    = in_idx_reg;
        out_idx_next   = out_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        n_next         = n_reg;
        mul_next       = mul_reg;
        sample_next    = sample_reg;
        res_next       = res_reg;
        neg_next       = neg_reg;

        mac_req           = '0;
        mac_req.wr_data   = sample_reg;
        mac_req.mean_last = n_reg[afd_pkg::TAP_W-1:0];
        div_req           = '0;
        div_req.num       = afd_pkg::DIV_NUM_W'({mul_reg, 1'b0})
                          + afd_pkg::DIV_NUM_W'(out_rate_reg);
        div_req.den       = afd_pkg::DIV_DEN_W'({out_rate_reg, 1'b0});

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    mac_req.clear = in_data.start_stream;
                    n_next        = in_data.start_stream ? '0 : in_idx_reg;
                    out_idx_next  = k_eff;
                    mul_next      = afd_pkg::MUL_W'(k_eff) * afd_pkg::MUL_W'(in_rate_reg);
                    sample_next   = stereo_reg ? pair_adj[afd_pkg::SAMPLE_W:1] : left_s;
                    state_next    = S_WRITE;
                end
            end
            S_WRITE:
            begin
                // Store the sample, start the sweep and, for valid rates, the target division
                mac_req.wr_en = 1'b1;
                mac_req.start = 1'b1;
                div_req.start = rate_ok;
                state_next    = S_RUN;
            end
            S_RUN:
            begin
                if (!mac_stat.busy && !div_stat.busy)
                begin
                    if (match && warm)
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = afd_pkg::DIV_NUM_W'(mean_mag);
                        div_req.den   = afd_pkg::DIV_DEN_W'(n_reg[afd_pkg::TAP_W-1:0])
                                      + afd_pkg::DIV_DEN_W'(1);
                        neg_next      = mac_stat.mean_sum[afd_pkg::ACC_W-1];
                        state_next    = S_MEAN;
                    end
                    else if (match)
                    begin
                        priority if (mac_stat.fir_sum > afd_pkg::SAT_HI)
                        begin
                            res_next.sample_out = afd_pkg::SAMPLE_MAX;
                            res_next.saturated  = 1'b1;
                        end
                        else if (mac_stat.fir_sum < afd_pkg::SAT_LO)
                        begin
                            res_next.sample_out = afd_pkg::SAMPLE_MIN;
                            res_next.saturated  = 1'b1;
                        end
                        else
                        begin
                            res_next.sample_out = mac_stat.fir_sum[afd_pkg::SAMPLE_W-1:0];
                            res_next.saturated  = 1'b0;
                        end
                        state_next = S_OUT;
                    end
                    else
                    begin
                        in_idx_next = n_reg + afd_pkg::INDEX_W'(1);
                        state_next  = S_IDLE;
                    end
                end
            end
            S_MEAN:
            begin
                if (!div_stat.busy)
                begin
                    res_next.sample_out = neg_reg ? -mean_q : mean_q;
                    res_next.saturated  = 1'b0;
                    state_next          = S_OUT;
                end
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    out_idx_next   = out_idx_reg + afd_pkg::INDEX_W'(1);
                    in_idx_next    = n_reg + afd_pkg::INDEX_W'(1);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_rate_reg   <= afd_pkg::IN_RATE_RESET;
            out_rate_reg  <= afd_pkg::OUT_RATE_RESET;
            stereo_reg    <= 1'b0;
            eight_bit_reg <= 1'b0;
            in_idx_reg    <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_rate_reg   <= in_rate_next;
            out_rate_reg  <= out_rate_next;
            stereo_reg    <= stereo_next;
            eight_bit_reg <= eight_bit_next;
            in_idx_reg    <= in_idx_next;
            out_idx_reg   <= out_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        n_reg        <= n_next;
        mul_reg      <= mul_next;
        sample_reg   <= sample_next;
        res_reg      <= res_next;
        neg_reg      <= neg_next;
    end

    // An accepted frame always goes straight to the history write
    assert property (@(posedge clk) disable iff (!rst_n) in_accept |=> state_reg == S_WRITE)
        else $error("core: accepted frame did not reach history write");

    // A clipped sample sits at one of the rails
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            out_data.sample_out == afd_pkg::SAMPLE_MAX ||
            out_data.sample_out == afd_pkg::SAMPLE_MIN)
        else $error("core: saturated flag without a rail value");

    // Each emitted sample advances the output index by one
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && out_free |=>
            out_idx_reg == $past(out_idx_reg) + afd_pkg::INDEX_W'(1))
        else $error("core: output index did not advance");

endmodule

`default_nettype wire

### design/afd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module afd_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/afd_div.sv
// Iterative unsigned divider, four quotient bits per cycle, low quotient bits kept.
// Depends on afd_pkg.
`default_nettype none

module afd_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire afd_pkg::div_req_t req,
    output afd_pkg::div_stat_t     stat
);

    logic                               busy_reg, busy_next;
    logic [afd_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [afd_pkg::DIV_NUM_W-1:0]      num_reg, num_next;
    logic [afd_pkg::DIV_DEN_W-1:0]      den_reg, den_next;
    logic [afd_pkg::DIV_DEN_W-1:0]      rem_reg, rem_next;
    logic [afd_pkg::QUO_W-1:0]          quo_reg, quo_next;
    logic [afd_pkg::DIV_DEN_W-1:0]      rem_step;
    logic [afd_pkg::QUO_W-1:0]          quo_step;

    // Four restoring steps on the running remainder
    always_comb
    begin
        logic [afd_pkg::DIV_DEN_W:0] trial;
        rem_step = rem_reg;
        quo_step = quo_reg;
        for (int i = 0; i < afd_pkg::DIV_RADIX_W; i++)
        begin
            trial = {rem_step, num_reg[afd_pkg::DIV_NUM_W-1-i]};
            if (trial >= {1'b0, den_reg})
            begin
                rem_step = afd_pkg::DIV_DEN_W'(trial - {1'b0, den_reg});
                quo_step = {quo_step[afd_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_step = trial[afd_pkg::DIV_DEN_W-1:0];
                quo_step = {quo_step[afd_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    // Load on start, advance while busy
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = afd_pkg::DIV_CNT_W'(afd_pkg::DIV_STEPS);
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            quo_next = quo_step;
            num_next = num_reg << afd_pkg::DIV_RADIX_W;
            cnt_next = cnt_reg - afd_pkg::DIV_CNT_W'(1);
            if (cnt_reg == afd_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.quo  = quo_reg;

    // A new division never lands on one in flight
    assert property (@(posedge clk) disable iff (!rst_n) req.start |-> !busy_reg)
        else $error("afd_div: start while busy");

endmodule

`default_nettype wire

### design/afd_mac.sv
// Sample history in a circular RAM and the tap sweep that reads it back.
// One tap per cycle: read, mask, multiply, truncate and accumulate.
// Depends on afd_pkg and afd_ram.
`default_nettype none

module afd_mac (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire afd_pkg::mac_req_t req,
    output afd_pkg::mac_stat_t     stat
);

    localparam logic signed [afd_pkg::PROD_W-1:0] ROUND_ADJ =
        afd_pkg::PROD_W'((64'd1 << afd_pkg::COEF_FRACTION_BITS) - 64'd1);

    logic                                busy_reg, busy_next;
    logic [afd_pkg::TAP_W:0]             issue_cnt_reg, issue_cnt_next;
    logic [afd_pkg::TAP_W-1:0]           head_reg, head_next;
    logic [afd_pkg::TAPS-1:0]            vbits_reg, vbits_next;
    logic [afd_pkg::TAP_W-1:0]           mean_last_reg;

    logic                                s1_v_reg, s2_v_reg, s3_v_reg;
    logic [afd_pkg::TAP_W-1:0]           s1_tap_reg, s2_tap_reg, s3_tap_reg;
    logic                                s1_vbit_reg;
    logic signed [afd_pkg::SAMPLE_W-1:0] s2_data_reg, s3_data_reg;
    logic signed [afd_pkg::PROD_W-1:0]   s3_prod_reg;
    logic signed [afd_pkg::ACC_W-1:0]    fir_acc_reg, fir_acc_next;
    logic signed [afd_pkg::ACC_W-1:0]    mean_acc_reg, mean_acc_next;

    logic                                issue;
    logic [afd_pkg::TAP_W-1:0]           rd_addr;
    logic [afd_pkg::TAP_W-1:0]           wr_addr;
    logic [afd_pkg::SAMPLE_W-1:0]        rd_data;
    logic signed [afd_pkg::SAMPLE_W-1:0] s1_data;
    logic [afd_pkg::TAP_W-2:0]           half_idx;
    logic signed [afd_pkg::PROD_W-1:0]   prod;
    logic signed [afd_pkg::PROD_W-1:0]   prod_adj;
    logic signed [afd_pkg::PROD_W-1:0]   prod_shift;
    logic signed [afd_pkg::TERM_W-1:0]   term;

    // Newest sample sits at head; tap i lies i entries behind it
    assign issue   = busy_reg && !issue_cnt_reg[afd_pkg::TAP_W];
    assign rd_addr = head_reg - issue_cnt_reg[afd_pkg::TAP_W-1:0];
    assign wr_addr = head_reg + afd_pkg::TAP_W'(1);

    afd_ram #(
        .WIDTH (afd_pkg::SAMPLE_W),
        .DEPTH (afd_pkg::TAPS)
    ) u_hist_ram (
        .clk     (clk),
        .we      (req.wr_en),
        .waddr   (wr_addr),
        .wdata   (req.wr_data),
        .re      (issue),
        .raddr   (rd_addr),
        .rd_data (rd_data)
    );

    // Mask entries not written since the stream began
    assign s1_data = s1_vbit_reg ? $signed(rd_data) : '0;

    // Fold the tap onto the half table and multiply
    assign half_idx = s2_tap_reg[afd_pkg::TAP_W-1] ? ~s2_tap_reg[afd_pkg::TAP_W-2:0]
                                                    : s2_tap_reg[afd_pkg::TAP_W-2:0];
    assign prod = s2_data_reg * $signed({1'b0, afd_pkg::COEF_HALF[half_idx]});

    // Truncate each product toward zero
    assign prod_adj   = s3_prod_reg + (s3_prod_reg[afd_pkg::PROD_W-1] ? ROUND_ADJ : '0);
    assign prod_shift = prod_adj >>> afd_pkg::COEF_FRACTION_BITS;
    assign term       = prod_shift[afd_pkg::TERM_W-1:0];

    // Control: write pointer, valid bits, sweep counter, accumulators
    always_comb
    begin
        busy_next      = busy_reg;
        issue_cnt_next = issue_cnt_reg;
        head_next      = head_reg;
        vbits_next     = vbits_reg;
        fir_acc_next   = fir_acc_reg;
        mean_acc_next  = mean_acc_reg;
        if (req.clear)
        begin
            vbits_next = '0;
        end
        if (req.wr_en)
        begin
            head_next           = wr_addr;
            vbits_next[wr_addr] = 1'b1;
        end
        if (req.start)
        begin
            busy_next      = 1'b1;
            issue_cnt_next = '0;
            fir_acc_next   = '0;
            mean_acc_next  = '0;
        end
        else
        begin
            if (issue)
            begin
                issue_cnt_next = issue_cnt_reg + (afd_pkg::TAP_W + 1)'(1);
            end
            if (s3_v_reg)
            begin
                fir_acc_next = fir_acc_reg + afd_pkg::ACC_W'(term);
                if (s3_tap_reg <= mean_last_reg)
                begin
                    mean_acc_next = mean_acc_reg + afd_pkg::ACC_W'(s3_data_reg);
                end
                if (s3_tap_reg == afd_pkg::TAP_W'(afd_pkg::TAPS - 1))
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            issue_cnt_reg <= '0;
            head_reg      <= '0;
            vbits_reg     <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            issue_cnt_reg <= issue_cnt_next;
            head_reg      <= head_next;
            vbits_reg     <= vbits_next;
            s1_v_reg      <= issue;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mean_last_reg <= req.mean_last;
        end
        s1_tap_reg   <= issue_cnt_reg[afd_pkg::TAP_W-1:0];
        s1_vbit_reg  <= vbits_reg[rd_addr];
        s2_tap_reg   <= s1_tap_reg;
        s2_data_reg  <= s1_data;
        s3_tap_reg   <= s2_tap_reg;
        s3_data_reg  <= s2_data_reg;
        s3_prod_reg  <= prod;
        fir_acc_reg  <= fir_acc_next;
        mean_acc_reg <= mean_acc_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.fir_sum  = fir_acc_reg;
    assign stat.mean_sum = mean_acc_reg;

    // The history is never written while a sweep reads it
    assert property (@(posedge clk) disable iff (!rst_n) req.wr_en |-> !busy_reg)
        else $error("afd_mac: history write during sweep");

endmodule

`default_nettype wire

### tb/sv/audio_fir_decimator_core_tb.sv
// Self-checking testbench for audio_fir_decimator_core: frame beats in, filtered samples out.
// A built-in decimator predictor queues the expected samples; depends on afd_pkg and the RTL.
`timescale 1ns / 1ps

module audio_fir_decimator_core_tb;

    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 550;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTS} stall_mode_t;

    // Block ports
    logic                         clk      = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    afd_pkg::afd_in_t             in_data  = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    afd_pkg::afd_out_t            out_data;
    logic                         psel     = 1'b0;
    logic                         penable  = 1'b0;
    logic                         pwrite   = 1'b0;
    logic [afd_pkg::PADDR_W-1:0]  paddr    = '0;
    logic [afd_pkg::PDATA_W-1:0]  pwdata   = '0;
    logic [afd_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    // Predictor copy of the registers and the stream state
    logic [afd_pkg::RATE_W-1:0]   cfg_in_rate  = 19'd44100;
    logic [afd_pkg::RATE_W-1:0]   cfg_out_rate = 19'd8000;
    logic                         cfg_stereo   = 1'b0;
    logic                         cfg_eight    = 1'b0;
    int                           hist [afd_pkg::TAPS];
    bit [31:0]                    frame_index  = '0;
    bit [31:0]                    sample_index = '0;
    afd_pkg::afd_out_t            pending_samples [$];

    int                           error_count = 0;
    int                           cycle_count = 0;
    logic [15:0]                  dc_level    = 16'h7FFF;

    // Receiver stall control
    stall_mode_t                  stall_mode  = STALL_NONE;
    int                           hold_reqs   = 0;
    int                           hold_seen   = 0;
    int                           hold_left   = 0;
    int                           stall_run   = 0;
    bit                           stall_phase = 1'b0;

    audio_fir_decimator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Symmetric tap weight, rounded half up to 16 fraction bits
    function automatic longint tap_weight(int tap);
        longint nano;
        int     half;
        half = (tap < 8) ? tap : 15 - tap;
        case (half)
            0:       nano = 3638091;
            1:       nano = 8158223;
            2:       nano = 20889028;
            3:       nano = 43770138;
            4:       nano = 74889944;
            5:       nano = 108669917;
            6:       nano = 137467074;
            default: nano = 154050524;
        endcase
        return ((nano <<< 16) + 64'sd500000000) / 64'sd1000000000;
    endfunction

    // Frame index on which output k falls, rounded to nearest
    function automatic bit [31:0] source_index(bit [31:0] k);
        bit [63:0] num;
        bit [63:0] den;
        num = 64'(k) * 64'(cfg_in_rate) * 64'd2 + 64'(cfg_out_rate);
        den = 64'(cfg_out_rate) * 64'd2;
        return 32'(num / den);
    endfunction

    function automatic logic [31:0] cfg_value(afd_pkg::reg_idx_t idx);
        case (idx)
            afd_pkg::REG_IN_RATE:  return 32'(cfg_in_rate);
            afd_pkg::REG_OUT_RATE: return 32'(cfg_out_rate);
            afd_pkg::REG_STEREO:   return 32'(cfg_stereo);
            default:               return 32'(cfg_eight);
        endcase
    endfunction

    // Push the sample that one accepted frame yields, if any
    task automatic decimate_frame(input afd_pkg::afd_in_t f);
        int                left;
        int                right;
        int                mono;
        int                total;
        longint            acc;
        longint            prod;
        longint            mag;
        bit                sat;
        afd_pkg::afd_out_t r;
        if (f.start_stream)
        begin
            foreach (hist[i])
                hist[i] = 0;
            frame_index  = '0;
            sample_index = '0;
        end
        if (cfg_eight)
        begin
            left  = $signed(f.left_sample[7:0]) * 256;
            right = $signed(f.right_sample[7:0]) * 256;
        end
        else
        begin
            left  = f.left_sample;
            right = f.right_sample;
        end
        mono = cfg_stereo ? (left + right) / 2 : left;
        for (int i = afd_pkg::TAPS - 1; i > 0; i--)
            hist[i] = hist[i - 1];
        hist[0] = mono;

        if (cfg_out_rate != 0 && cfg_in_rate >= cfg_out_rate
            && frame_index == source_index(sample_index))
        begin
            sat = 1'b0;
            if (frame_index < afd_pkg::WARMUP_LEN)
            begin
                // Warm-up: truncated mean of the frames so far
                total = 0;
                for (int i = 0; i <= int'(frame_index); i++)
                    total += hist[i];
                r.sample_out = 16'(total / int'(frame_index + 1));
            end
            else
            begin
                // Full filter: truncate each product toward zero, then clip
                acc = 0;
                for (int i = 0; i < afd_pkg::TAPS; i++)
                begin
                    prod = longint'(hist[i]) * tap_weight(i);
                    mag  = (prod < 0) ? -prod : prod;
                    acc += (prod < 0) ? -(mag >>> 16) : (mag >>> 16);
                end
                if (acc > 32767)
                begin
                    acc = 32767;
                    sat = 1'b1;
                end
                else if (acc < -32768)
                begin
                    acc = -32768;
                    sat = 1'b1;
                end
                r.sample_out = 16'(acc);
            end
            r.saturated = sat;
            pending_samples.push_back(r);
            sample_index++;
        end
        frame_index++;
    endtask

    // Compare each output beat with the oldest expected sample
    always @(posedge clk)
    begin : check_output
        afd_pkg::afd_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("unexpected sample_out %0d", out_data.sample_out);
                error_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (out_data.sample_out !== want.sample_out)
                begin
                    $error("sample_out: expected %0d, got %0d",
                           want.sample_out, out_data.sample_out);
                    error_count++;
                end
                if (out_data.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, out_data.saturated);
                    error_count++;
                end
            end
        end
    end

    // Drive out_stall: long hold on request, else the current pattern
    always @(posedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
                default:
                begin
                    if (stall_run == 0)
                    begin
                        stall_phase = !stall_phase;
                        stall_run   = $urandom_range(1, 24);
                    end
                    stall_run--;
                    out_stall <= stall_phase;
                end
            endcase
        end
    end

    // Offer one frame beat and hold it until accepted
    task automatic send_frame(input afd_pkg::afd_in_t f);
        in_valid <= 1'b1;
        in_data  <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decimate_frame(f);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Drop valid, wait for every expected sample, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB transfer; psel stays high so transfers can run back to back
    task automatic apb_transfer(input bit wr, input afd_pkg::reg_idx_t idx,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        if (wr)
        begin
            case (idx)
                afd_pkg::REG_IN_RATE:  cfg_in_rate  = wdata[afd_pkg::RATE_W-1:0];
                afd_pkg::REG_OUT_RATE: cfg_out_rate = wdata[afd_pkg::RATE_W-1:0];
                afd_pkg::REG_STEREO:   cfg_stereo   = wdata[0];
                default:               cfg_eight    = wdata[0];
            endcase
        end
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_config(input int in_rate, input int out_rate,
                                input bit stereo, input bit eight);
        logic [31:0] unused;
        apb_transfer(1'b1, afd_pkg::REG_IN_RATE, in_rate, unused);
        apb_transfer(1'b1, afd_pkg::REG_OUT_RATE, out_rate, unused);
        apb_transfer(1'b1, afd_pkg::REG_STEREO, 32'(stereo), unused);
        apb_transfer(1'b1, afd_pkg::REG_EIGHT_BIT, 32'(eight), unused);
        apb_release();
    endtask

    function automatic afd_pkg::afd_in_t make_frame(bit start, logic [15:0] l, logic [15:0] r);
        afd_pkg::afd_in_t f;
        f.start_stream = start;
        f.left_sample  = l;
        f.right_sample = r;
        return f;
    endfunction

    // Sample for the current style; extremes move to the low byte in 8-bit mode
    function automatic logic [15:0] pick_sample(int style);
        logic [15:0] v;
        case (style)
            0: v = 16'($urandom);
            1: v = ($urandom_range(0, 7) == 0) ? 16'($urandom) : dc_level;
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       v = 16'h7FFF;
                    1:       v = 16'h8000;
                    2:       v = 16'h0000;
                    3:       v = 16'hFFFF;
                    4:       v = 16'h0001;
                    default: v = 16'($urandom);
                endcase
            end
        endcase
        if (style != 0 && cfg_eight)
            v = {8'($urandom), v[15:8]};
        return v;
    endfunction

    // Reset values, then write and read back every register
    task automatic test_register_access();
        logic [31:0]       got;
        logic [31:0]       fresh [4] = '{384000, 1, 1, 1};
        afd_pkg::reg_idx_t idx;
        for (int i = 0; i < 4; i++)
        begin
            idx = afd_pkg::reg_idx_t'(i);
            apb_transfer(1'b0, idx, '0, got);
            if (got !== cfg_value(idx))
            begin
                $error("reset %s: expected %0d, got %0d", idx.name(), cfg_value(idx), got);
                error_count++;
            end
            apb_transfer(1'b1, idx, fresh[i], got);
            apb_transfer(1'b0, idx, '0, got);
            if (got !== cfg_value(idx))
            begin
                $error("readback %s: expected %0d, got %0d", idx.name(), cfg_value(idx), got);
                error_count++;
            end
        end
        apb_release();
    endtask

    // One output per frame: warm-up means with extremes and negative truncation
    task automatic test_warmup_mean();
        wait_drained();
        write_config(1, 1, 1'b0, 1'b0);
        stall_mode = STALL_RANDOM;
        send_frame(make_frame(1'b1, 16'h7FFF, 16'h1234));
        send_frame(make_frame(1'b0, 16'h7FFF, 16'h8000));
        send_frame(make_frame(1'b0, 16'h8000, 16'hFFFF));
        send_frame(make_frame(1'b0, 16'h8000, 16'h7FFF));
        send_frame(make_frame(1'b0, 16'hFFFF, 16'h0000));
    endtask

    // Stereo averaging, 8-bit scaling and ignored high bytes
    task automatic test_sample_formats();
        wait_drained();
        write_config(1, 1, 1'b1, 1'b0);
        send_frame(make_frame(1'b1, 16'h7FFF, 16'h7FFF));
        send_frame(make_frame(1'b0, 16'h8000, 16'h8000));
        send_frame(make_frame(1'b0, 16'h7FFF, 16'h8000));
        wait_drained();
        write_config(1, 1, 1'b1, 1'b1);
        send_frame(make_frame(1'b1, 16'hA57F, 16'h3C80));
        send_frame(make_frame(1'b0, 16'hFF01, 16'h00FF));
        send_frame(make_frame(1'b0, 16'h12FF, 16'hEDFE));
        wait_drained();
        write_config(1, 1, 1'b0, 1'b1);
        send_frame(make_frame(1'b1, 16'h5A80, 16'h7F7F));
    endtask

    // Rate extremes: single output, no output, every frame
    task automatic test_rate_extremes();
        wait_drained();
        write_config(384000, 1, 1'b0, 1'b0);
        send_frame(make_frame(1'b1, 16'h4000, 16'h0000));
        send_frame(make_frame(1'b0, 16'hC000, 16'h0000));
        wait_drained();
        write_config(8000, 44100, 1'b0, 1'b0);
        send_frame(make_frame(1'b1, 16'h7FFF, 16'h0000));
        wait_drained();
        write_config(1, 384000, 1'b0, 1'b0);
        send_frame(make_frame(1'b1, 16'h8000, 16'h0000));
        wait_drained();
        write_config(384000, 384000, 1'b0, 1'b0);
        send_frame(make_frame(1'b1, 16'h0100, 16'h0000));
        send_frame(make_frame(1'b0, 16'hFF00, 16'h0000));
    endtask

    // Lower the ratio mid-stream so the target falls behind, then restart
    task automatic test_rate_change_midstream();
        wait_drained();
        write_config(2, 1, 1'b0, 1'b0);
        stall_mode = STALL_BURSTS;
        send_frame(make_frame(1'b1, 16'h1000, 16'h0000));
        send_frame(make_frame(1'b0, 16'h2000, 16'h0000));
        send_frame(make_frame(1'b0, 16'h3000, 16'h0000));
        send_frame(make_frame(1'b0, 16'h4000, 16'h0000));
        wait_drained();
        write_config(1, 1, 1'b0, 1'b0);
        send_frame(make_frame(1'b0, 16'h5000, 16'h0000));
        send_frame(make_frame(1'b0, 16'h6000, 16'h0000));
        send_frame(make_frame(1'b1, 16'h7000, 16'h0000));
    endtask

    // Hold the output off for a long stretch while frames keep coming
    task automatic test_output_backpressure();
        wait_drained();
        write_config(1, 1, 1'b0, 1'b0);
        stall_mode = STALL_NONE;
        hold_reqs++;
        for (int i = 0; i < 12; i++)
            send_frame(make_frame(i == 0, 16'($urandom), 16'($urandom)));
        wait_drained();
    endtask

    // Streams under random settings, bursts and stall patterns
    task automatic test_random_streams();
        int  sent;
        int  len;
        int  burst_left;
        int  style;
        int  in_rate;
        int  out_rate;
        bit  gaps;
        bit  start;
        sent       = 0;
        burst_left = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_drained();
            len = $urandom_range(16, 64);
            case ($urandom_range(0, 9))
                0: begin in_rate = 44100;  out_rate = 8000;   end
                1: begin in_rate = 48000;  out_rate = 16000;  end
                2: begin in_rate = 1;      out_rate = 1;      end
                3: begin in_rate = 384000; out_rate = 384000; end
                4: begin in_rate = 3;      out_rate = 2;      end
                5: begin in_rate = 384000; out_rate = 1;      len = 12; end
                6: begin in_rate = 8000;   out_rate = 44100;  len = 12; end
                9: begin in_rate = 11025;  out_rate = 8000;   end
                default:
                begin
                    in_rate  = $urandom_range(1, 384000);
                    out_rate = $urandom_range((in_rate + 7) / 8, in_rate);
                end
            endcase
            write_config(in_rate, out_rate, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            gaps       = ($urandom_range(0, 2) != 0);
            style      = $urandom_range(0, 2);
            dc_level   = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;

            for (int j = 0; j < len; j++)
            begin
                // Start a new burst after a random gap
                if (gaps && burst_left == 0)
                begin
                    idle_cycles($urandom_range(0, 8));
                    burst_left = $urandom_range(1, 16);
                end
                if (burst_left > 0)
                    burst_left--;
                // Occasionally pause until every sample is out
                if (j != 0 && $urandom_range(0, 63) == 0)
                    wait_drained();
                start = (j == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 47) == 0);
                send_frame(make_frame(start, pick_sample(style), pick_sample(style)));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_warmup_mean();
        test_sample_formats();
        test_rate_extremes();
        test_rate_change_midstream();
        test_output_backpressure();
        test_random_streams();
        wait_drained();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
